FILE: design/afs_pkg.sv
// ----------------------------------------------------------------------------
// afs_pkg
// Shared types and constants of the animation frame sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package afs_pkg;

    localparam int KIND_W      = 2;
    localparam int DT_W        = 16;
    localparam int FT_W        = 9;
    localparam int DUR_W       = 20;
    localparam int DIR_W       = 2;
    localparam int STAT_W      = 2;
    localparam int OUT_FRAME_W = 8;
    localparam int SCALED_W    = 26;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;

    localparam logic [DUR_W-1:0] DELAY_MAX = {DUR_W{1'b1}};

    // item kinds
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PLAY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PAUSE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_STOP  = 2'd3;

    // play directions
    localparam logic [DIR_W-1:0] DIR_FWD      = 2'd0;
    localparam logic [DIR_W-1:0] DIR_REV      = 2'd1;
    localparam logic [DIR_W-1:0] DIR_PINGPONG = 2'd2;
    localparam logic [DIR_W-1:0] DIR_PONGPING = 2'd3;

    // run status codes
    localparam logic [STAT_W-1:0] STAT_PLAYING = 2'd0;
    localparam logic [STAT_W-1:0] STAT_PAUSED  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ENDED   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TOTAL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_DURATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_DIRECTION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_ENABLE  = 3'd4;

    typedef struct packed {
        logic                start;
        logic [SCALED_W-1:0] dividend;
        logic [DUR_W-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [SCALED_W-1:0] quot;
        logic [DUR_W-1:0]    rem;
    } t_div_rsp;

    function automatic logic [STAT_W-1:0] run_status(input logic playing,
                                                     input logic ended);
        logic [STAT_W-1:0] s;
        if (playing) begin
            s = STAT_PLAYING;
        end else if (!ended) begin
            s = STAT_PAUSED;
        end else begin
            s = STAT_ENDED;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: design/animation_frame_sequencer_core.sv
// ----------------------------------------------------------------------------
// animation_frame_sequencer_core
// Frame sequencer (forward, reverse, ping-pong, pong-ping): ticks and
// play/pause/stop items in, one frame index and run status out per item.
// ----------------------------------------------------------------------------
// Play, pause, stop and idle or delay-filling ticks are answered straight from
// idle. A frame-advancing tick accumulates, runs the shared divider, runs it
// again with repeat on to fold the step count by the sequence period, then makes
// one frame step per cycle (at most 4 * frame count steps). Throughput: one item at a time.
// Reset: synchronous active low; reset registers take their listed values and
// the ended flag is set; the output frame and status registers are not reset.
`default_nettype none

module animation_frame_sequencer_core #(
    parameter int MAX_FRAMES = 256
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [afs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [afs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [afs_pkg::KIND_W-1:0]     i_kind,
    input  wire logic [afs_pkg::DT_W-1:0]       i_tick_time,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [afs_pkg::OUT_FRAME_W-1:0]     o_frame_index,
    output logic [afs_pkg::STAT_W-1:0]          o_run_status
);
    import afs_pkg::*;

    localparam int FT_MAX = (1 << FT_W) - 1;
    localparam int N_MAX  = (MAX_FRAMES < FT_MAX) ? MAX_FRAMES : FT_MAX;
    localparam int NW     = $clog2(N_MAX + 1);
    localparam int FW     = $clog2(N_MAX);
    localparam int PW     = NW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACC  = 3'd1;
    localparam logic [2:0] S_QGO  = 3'd2;
    localparam logic [2:0] S_QUOT = 3'd3;
    localparam logic [2:0] S_FOLD = 3'd4;
    localparam logic [2:0] S_MOD  = 3'd5;
    localparam logic [2:0] S_STEP = 3'd6;

    // configuration
    logic [FT_W-1:0]     r_frame_total;
    logic [DUR_W-1:0]    r_cycle_duration;
    logic [DUR_W-1:0]    r_start_delay;
    logic [DIR_W-1:0]    r_play_direction;
    logic                r_repeat_enable;

    // sequencer state
    logic [2:0]          r_state,    n_state;
    logic [FW-1:0]       r_frame,    n_frame;
    logic [SCALED_W-1:0] r_scaled,   n_scaled;
    logic [DUR_W-1:0]    r_delay,    n_delay;
    logic                r_playing,  n_playing;
    logic                r_ended,    n_ended;
    logic                r_bounce,   n_bounce;
    logic [SCALED_W-1:0] r_steps,    n_steps;
    logic [DT_W-1:0]     r_dt,       n_dt;
    logic                r_out_valid;
    logic [OUT_FRAME_W-1:0] r_out_frame;
    logic [STAT_W-1:0]   r_out_stat;

    logic [NW-1:0]       n_count;
    logic [FW-1:0]       last;
    logic [PW-1:0]       period;
    logic [DUR_W-1:0]    dur;
    logic [FW-1:0]       halt_frame;
    logic [DUR_W:0]      delay_sum;
    logic                accept;
    logic                emit;

    logic [FW-1:0]       step_frame;
    logic                step_bounce;
    logic                step_end;

    t_div_req            div_req;
    t_div_rsp            div_rsp;

    afs_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    afs_frame_step #(.FW(FW)) u_step (
        .i_frame  (r_frame),
        .i_last   (last),
        .i_dir    (r_play_direction),
        .i_bounce (r_bounce),
        .o_frame  (step_frame),
        .o_bounce (step_bounce),
        .o_at_end (step_end)
    );

    always_comb begin
        if (r_frame_total == '0) begin
            n_count = NW'(1);
        end else if (32'(r_frame_total) > N_MAX) begin
            n_count = NW'(N_MAX);
        end else begin
            n_count = NW'(r_frame_total);
        end
    end

    assign last       = FW'(n_count - 1'b1);
    assign period     = r_play_direction[1] ? {n_count, 1'b0} : {1'b0, n_count};
    assign dur        = (r_cycle_duration == '0) ? DUR_W'(1) : r_cycle_duration;
    assign halt_frame = (r_play_direction == DIR_FWD || r_play_direction == DIR_PINGPONG)
                        ? '0 : last;
    assign delay_sum  = {1'b0, r_delay} + (DUR_W + 1)'(i_tick_time);

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = r_scaled;
        div_req.divisor  = dur;
        if (r_state == S_QGO) begin
            div_req.start = 1'b1;
        end else if (r_state == S_FOLD) begin
            div_req.start    = r_repeat_enable
                               && (r_steps > (SCALED_W'(period) << 1));
            div_req.dividend = r_steps - SCALED_W'(period);
            div_req.divisor  = DUR_W'(period);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_frame   = r_frame;
        n_scaled  = r_scaled;
        n_delay   = r_delay;
        n_playing = r_playing;
        n_ended   = r_ended;
        n_bounce  = r_bounce;
        n_steps   = r_steps;
        n_dt      = r_dt;
        emit      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_kind)
                        KIND_TICK: begin
                            if (!r_playing) begin
                                emit = 1'b1;
                            end else if (r_delay < r_start_delay) begin
                                n_delay = delay_sum[DUR_W] ? DELAY_MAX
                                                           : delay_sum[DUR_W-1:0];
                                emit    = 1'b1;
                            end else begin
                                if (r_frame > last) begin
                                    n_frame = last;
                                end
                                n_dt    = i_tick_time;
                                n_state = S_ACC;
                            end
                        end
                        KIND_PLAY: begin
                            n_playing = 1'b1;
                            n_ended   = 1'b0;
                            emit      = 1'b1;
                        end
                        KIND_PAUSE: begin
                            n_playing = 1'b0;
                            emit      = 1'b1;
                        end
                        default: begin
                            n_scaled  = '0;
                            n_frame   = halt_frame;
                            n_playing = 1'b0;
                            n_ended   = 1'b1;
                            n_bounce  = 1'b0;
                            emit      = 1'b1;
                        end
                    endcase
                end
            end
            S_ACC: begin
                n_scaled = r_scaled + SCALED_W'(r_dt) * SCALED_W'(n_count);
                n_state  = S_QGO;
            end
            S_QGO: begin
                n_state = S_QUOT;
            end
            S_QUOT: begin
                if (div_rsp.done) begin
                    n_steps  = div_rsp.quot;
                    n_scaled = SCALED_W'(div_rsp.rem);
                    n_state  = S_FOLD;
                end
            end
            S_FOLD: begin
                n_state = div_req.start ? S_MOD : S_STEP;
            end
            S_MOD: begin
                if (div_rsp.done) begin
                    n_steps = SCALED_W'(period) + SCALED_W'(div_rsp.rem);
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (r_steps == '0) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_frame  = step_frame;
                    n_bounce = step_bounce;
                    n_steps  = r_steps - 1'b1;
                    if (step_end) begin
                        n_delay = '0;
                        if (!r_repeat_enable) begin
                            n_scaled  = '0;
                            n_frame   = halt_frame;
                            n_playing = 1'b0;
                            n_ended   = 1'b1;
                            n_bounce  = 1'b0;
                            emit      = 1'b1;
                            n_state   = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_total    <= FT_W'(1);
            r_cycle_duration <= DUR_W'(1);
            r_start_delay    <= '0;
            r_play_direction <= DIR_FWD;
            r_repeat_enable  <= 1'b0;
            r_state          <= S_IDLE;
            r_frame          <= '0;
            r_scaled         <= '0;
            r_delay          <= '0;
            r_playing        <= 1'b0;
            r_ended          <= 1'b1;
            r_bounce         <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FRAME_TOTAL:    r_frame_total    <= i_cfg_data[FT_W-1:0];
                    CFG_CYCLE_DURATION: r_cycle_duration <= i_cfg_data[DUR_W-1:0];
                    CFG_START_DELAY:    r_start_delay    <= i_cfg_data[DUR_W-1:0];
                    CFG_PLAY_DIRECTION: r_play_direction <= i_cfg_data[DIR_W-1:0];
                    CFG_REPEAT_ENABLE:  r_repeat_enable  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_state   <= n_state;
            r_frame   <= n_frame;
            r_scaled  <= n_scaled;
            r_delay   <= n_delay;
            r_playing <= n_playing;
            r_ended   <= n_ended;
            r_bounce  <= n_bounce;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_steps <= n_steps;
        r_dt    <= n_dt;
        if (emit) begin
            r_out_frame <= OUT_FRAME_W'(n_frame);
            r_out_stat  <= run_status(n_playing, n_ended);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_frame_index = r_out_frame;
    assign o_run_status  = r_out_stat;

`ifndef SYNTHESIS
    a_play_not_ended: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_playing && r_ended))
        else $error("playing while ended");

    a_frame_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (r_frame <= last))
        else $error("frame beyond last while stepping");

    a_steps_folded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP && r_repeat_enable) |-> (r_steps <= (SCALED_W'(period) << 1)))
        else $error("step count not folded by period");

    a_div_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_QUOT || r_state == S_MOD))
        else $error("divider result outside a wait state");
`endif

endmodule

`default_nettype wire

FILE: design/afs_divider.sv
// ----------------------------------------------------------------------------
// afs_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module afs_divider (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire afs_pkg::t_div_req i_req,
    output afs_pkg::t_div_rsp      o_rsp
);
    import afs_pkg::*;

    localparam int CNT_W = $clog2(SCALED_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SCALED_W - 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [SCALED_W-1:0] r_quo;
    logic [DUR_W-1:0]    r_rem;
    logic [DUR_W-1:0]    r_dvs;

    logic [DUR_W:0]      shifted;
    logic [DUR_W:0]      diff;
    logic                ge;

    assign shifted = {r_rem, r_quo[SCALED_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign ge      = (shifted >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DUR_W-1:0] : shifted[DUR_W-1:0];
            r_quo <= {r_quo[SCALED_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

FILE: design/afs_frame_step.sv
// ----------------------------------------------------------------------------
// afs_frame_step
// One frame step in the selected direction, with bounce and end detection.
// ----------------------------------------------------------------------------
`default_nettype none

module afs_frame_step #(
    parameter int FW = 8
) (
    input  wire logic [FW-1:0]             i_frame,
    input  wire logic [FW-1:0]             i_last,
    input  wire logic [afs_pkg::DIR_W-1:0] i_dir,
    input  wire logic                      i_bounce,
    output logic      [FW-1:0]             o_frame,
    output logic                           o_bounce,
    output logic                           o_at_end
);
    import afs_pkg::*;

    logic up;

    always_comb begin
        unique case (i_dir)
            DIR_FWD:      up = 1'b1;
            DIR_REV:      up = 1'b0;
            DIR_PINGPONG: up = !i_bounce;
            default:      up = i_bounce;
        endcase
    end

    always_comb begin
        o_frame  = i_frame;
        o_bounce = i_bounce;
        o_at_end = 1'b0;
        if (up) begin
            if (i_frame >= i_last) begin
                if (i_dir == DIR_FWD) begin
                    o_frame  = '0;
                    o_at_end = 1'b1;
                end else if (i_dir == DIR_PINGPONG) begin
                    o_frame  = i_last;
                    o_bounce = 1'b1;
                end else begin
                    o_frame  = i_last;
                    o_bounce = 1'b0;
                    o_at_end = 1'b1;
                end
            end else begin
                o_frame = i_frame + 1'b1;
            end
        end else begin
            if (i_frame == '0) begin
                if (i_dir == DIR_REV) begin
                    o_frame  = i_last;
                    o_at_end = 1'b1;
                end else if (i_dir == DIR_PONGPING) begin
                    o_frame  = '0;
                    o_bounce = 1'b1;
                end else begin
                    o_frame  = '0;
                    o_bounce = 1'b0;
                    o_at_end = 1'b1;
                end
            end else begin
                o_frame = i_frame - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire
